>>> rtl/core/bmhq_pkg.sv
// ---------------------------------------------------------------------------
// bmhq_pkg
// shared codes, field widths and cell control types for the max priority queue
// ---------------------------------------------------------------------------
package bmhq_pkg;

  // fixed payload widths of the input and result beats
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned ENTRY_W  = 7;
  localparam int unsigned STATUS_W = 2;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } cell_cmd_t;

endpackage

>>> rtl/core/bmhq_in_if.sv
// ---------------------------------------------------------------------------
// bmhq_in_if
// request channel: valid/ready handshake with operation and value
// ---------------------------------------------------------------------------
interface bmhq_in_if;

  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [bmhq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);

endinterface

>>> rtl/core/bmhq_out_if.sv
// ---------------------------------------------------------------------------
// bmhq_out_if
// result channel: valid/ready handshake with status, top value and count
// ---------------------------------------------------------------------------
interface bmhq_out_if;

  logic                                 valid;
  logic                                 ready;
  logic [bmhq_pkg::STATUS_W-1:0]        status;
  logic signed [bmhq_pkg::VALUE_W-1:0]  top_value;
  logic [bmhq_pkg::ENTRY_W-1:0]         entry_total;
  logic                                 is_empty;

  modport source (output valid, output status, output top_value, output entry_total,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input top_value, input entry_total,
                  input is_empty, output ready);

endinterface

>>> rtl/core/binary_max_heap_queue.sv
// result: registered, valid in the cycle after its request beat is accepted
// throughput: one request per cycle while the result slot is free or being drained; every
//   cell compares against the new key in parallel, so insertion and removal update the whole chain at once
// reset: occupancy bits, count and the result valid are cleared; stored keys are not
//   reset and are only read once marked occupied
// ---------------------------------------------------------------------------
// binary_max_heap_queue
// max priority queue built as a sorted chain of cells, largest key at the root
// ---------------------------------------------------------------------------
module binary_max_heap_queue #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bmhq_in_if.sink           in_i,
  bmhq_out_if.source        out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  // flipping the sign bit lets an unsigned compare order signed values
  localparam logic [DATA_WIDTH-1:0] SignBit = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

  // chain state, index 0 is the root (largest key)
  logic [DEPTH-1:0]      cell_vld;
  logic [DEPTH-1:0]      cell_ge;
  logic [DATA_WIDTH-1:0] cell_key [DEPTH];

  logic [CntW-1:0]       count_q, count_d;
  logic                  in_acc;
  logic                  full, empty;
  logic [DATA_WIDTH-1:0] new_key;
  bmhq_pkg::cell_cmd_t   cmd;
  logic [bmhq_pkg::STATUS_W-1:0] status_d;

  // root value after this beat, worked out alongside the cells
  logic                  root_vld_d;
  logic [DATA_WIDTH-1:0] root_key_d;

  // result register
  logic                          out_vld_q;
  logic [bmhq_pkg::STATUS_W-1:0] status_q;
  logic [bmhq_pkg::VALUE_W-1:0]  top_q, top_d;
  logic [bmhq_pkg::ENTRY_W-1:0]  total_q;
  logic                          empty_q;

  // accept a new beat whenever the result slot is free or being drained
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign full    = (count_q == CntW'(DEPTH));
  assign empty   = (count_q == '0);
  assign new_key = DATA_WIDTH'($unsigned(in_i.value)) ^ SignBit;

  always_comb begin
    cmd      = '0;
    status_d = bmhq_pkg::ST_DONE;
    count_d  = count_q;
    if (in_acc) begin
      if (in_i.op == bmhq_pkg::OP_PUSH) begin
        if (full) begin
          status_d = bmhq_pkg::ST_PUSH_FULL;
        end else begin
          cmd.push = 1'b1;
          count_d  = count_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          status_d = bmhq_pkg::ST_POP_EMPTY;
        end else begin
          cmd.pop = 1'b1;
          count_d = count_q - CntW'(1);
        end
      end
    end
  end

  // next root: new key if it beats the root, second entry after a pop
  always_comb begin
    root_vld_d = cell_vld[0];
    root_key_d = cell_key[0];
    if (cmd.push && !cell_ge[0]) begin
      root_vld_d = 1'b1;
      root_key_d = new_key;
    end else if (cmd.pop) begin
      root_vld_d = cell_vld[1];
      root_key_d = cell_key[1];
    end
  end

  assign top_d = root_vld_d ? bmhq_pkg::VALUE_W'(root_key_d ^ SignBit) : '0;

  // chain of cells, each linked to its upper and lower neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                  up_vld;
    logic [DATA_WIDTH-1:0] up_key;
    logic                  up_ge;
    logic                  dn_vld;
    logic [DATA_WIDTH-1:0] dn_key;

    if (g == 0) begin : g_root
      // the root always takes the new key when it cannot keep its own
      assign up_vld = 1'b0;
      assign up_key = '0;
      assign up_ge  = 1'b1;
    end else begin : g_mid
      assign up_vld = cell_vld[g-1];
      assign up_key = cell_key[g-1];
      assign up_ge  = cell_ge[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign dn_vld = 1'b0;
      assign dn_key = '0;
    end else begin : g_body
      assign dn_vld = cell_vld[g+1];
      assign dn_key = cell_key[g+1];
    end

    bmhq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .key_i    (new_key),
      .up_vld_i (up_vld),
      .up_key_i (up_key),
      .up_ge_i  (up_ge),
      .dn_vld_i (dn_vld),
      .dn_key_i (dn_key),
      .vld_o    (cell_vld[g]),
      .key_o    (cell_key[g]),
      .ge_o     (cell_ge[g])
    );
  end

  // entry count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with the beat that produced it
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      top_q    <= top_d;
      total_q  <= bmhq_pkg::ENTRY_W'(count_d);
      empty_q  <= (count_d == '0);
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = status_q;
  assign out_o.top_value   = top_q;
  assign out_o.entry_total = total_q;
  assign out_o.is_empty    = empty_q;

`ifndef SYNTHESIS
  // occupied cells always form a contiguous run from the root
  a_vld_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_vld[DEPTH-1:1] & ~cell_vld[DEPTH-2:0]) == '0))
    else $error("occupied cells are not contiguous");

  // count tracks the number of occupied cells
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(cell_vld) == count_q))
    else $error("entry count disagrees with occupied cells");

  // a push into a non-full queue grows it by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.op == bmhq_pkg::OP_PUSH && !full) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("push did not add an entry");

  // the root never holds a key below its neighbor
  a_root_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_vld[1] |-> (cell_key[0] >= cell_key[1])))
    else $error("root key below second entry");

  // every accepted beat is followed by a result beat
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_vld_q)
    else $error("accepted beat produced no result");
`endif

endmodule

>>> rtl/core/bmhq_cell.sv
// ---------------------------------------------------------------------------
// bmhq_cell
// one slot of the sorted chain: holds a key, inserts or shifts on command
// ---------------------------------------------------------------------------
module bmhq_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bmhq_pkg::cell_cmd_t   cmd_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  input  logic                  up_vld_i,
  input  logic [DATA_WIDTH-1:0] up_key_i,
  input  logic                  up_ge_i,
  input  logic                  dn_vld_i,
  input  logic [DATA_WIDTH-1:0] dn_key_i,
  output logic                  vld_o,
  output logic [DATA_WIDTH-1:0] key_o,
  output logic                  ge_o
);

  logic                  vld_q, vld_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;

  // slot holds its place when its key is not below the incoming one
  assign ge_o = vld_q & (key_q >= key_i);

  always_comb begin
    vld_d = vld_q;
    key_d = key_q;
    if (cmd_i.push) begin
      if (!ge_o) begin
        if (up_ge_i) begin
          vld_d = 1'b1;
          key_d = key_i;
        end else begin
          vld_d = up_vld_i;
          key_d = up_key_i;
        end
      end
    end else if (cmd_i.pop) begin
      vld_d = dn_vld_i;
      key_d = dn_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign vld_o = vld_q;
  assign key_o = key_q;

endmodule
